### rtl/rms_pkg.sv
`timescale 1ns / 1ps

package rms_pkg;

  // Grid geometry and element size
  localparam int MAX_COLUMNS   = 64;
  localparam int MAX_ROWS      = 64;
  localparam int ELEMENT_WIDTH = 32;

  // Remap chains share one cell count, big enough for either dimension
  localparam int MAP_DEPTH  = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
  localparam int MAP_W      = $clog2(MAP_DEPTH);
  localparam int GRID_DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W     = $clog2(GRID_DEPTH);
  localparam int CCNT_W     = $clog2(MAX_COLUMNS + 1);
  localparam int RCNT_W     = $clog2(MAX_ROWS + 1);

  // Port field widths
  localparam int OP_W       = 3;
  localparam int COL_FW     = 6;
  localparam int ROW_FW     = 6;
  localparam int VAL_W      = 32;
  localparam int CNT_FW     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Operation codes
  localparam logic [OP_W-1:0] OP_READ       = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE      = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE_ROW = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE_COL = 3'd3;
  localparam logic [OP_W-1:0] OP_RESTART    = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ROWS    = 2'd1;

  localparam logic [CNT_FW-1:0] START_RESET = 7'd64;

  // Control handed from the sequencer to one remap chain
  typedef struct packed {
    logic             restart;
    logic             shift;
    logic [MAP_W-1:0] pos;
  } map_ctrl_t;

  // Restart size: zero becomes one, oversize becomes the maximum
  function automatic int clamp_size(logic [CNT_FW-1:0] v, int maxv);
    int r;
    r = int'(v);
    if (r == 0) r = 1;
    else if (r > maxv) r = maxv;
    return r;
  endfunction

  // Input value to stored element (sign-extend, then keep the low bits)
  function automatic logic [ELEMENT_WIDTH-1:0] to_elem(logic signed [VAL_W-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[ELEMENT_WIDTH-1:0];
  endfunction

  // Stored element to output value (sign-extend from element width)
  function automatic logic [VAL_W-1:0] from_elem(logic [ELEMENT_WIDTH-1:0] e);
    logic signed [ELEMENT_WIDTH-1:0] es;
    logic signed [63:0]              w;
    es = e;
    w  = 64'(es);
    return w[VAL_W-1:0];
  endfunction

endpackage

### rtl/rms_ram.sv
`timescale 1ns / 1ps

module rms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

### rtl/rms_map_cell.sv
`timescale 1ns / 1ps

module rms_map_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  rms_pkg::map_ctrl_t        ctrl,
  input  logic [rms_pkg::MAP_W-1:0] index,
  input  logic [rms_pkg::MAP_W-1:0] from_next,
  output logic [rms_pkg::MAP_W-1:0] value
);

  import rms_pkg::*;

  // Holds one remap entry; on a remove, cells at or past the hole take
  // their right neighbor's entry
  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      value <= index;
    end else if (ctrl.shift && (index >= ctrl.pos)) begin
      value <= from_next;
    end
  end

endmodule

### rtl/rms_map_chain.sv
`timescale 1ns / 1ps

module rms_map_chain (
  input  logic                      clk,
  input  logic                      rst,
  input  rms_pkg::map_ctrl_t        ctrl,
  input  logic [rms_pkg::MAP_W-1:0] index,
  output logic [rms_pkg::MAP_W-1:0] value
);

  import rms_pkg::*;

  logic [MAP_W-1:0] cell_val [MAP_DEPTH];

  // Row of cells, each fed by its right neighbor; the last one feeds itself
  for (genvar i = 0; i < MAP_DEPTH; i++) begin : g_cell
    logic [MAP_W-1:0] nxt;
    if (i < MAP_DEPTH - 1) begin : g_mid
      assign nxt = cell_val[i+1];
    end else begin : g_end
      assign nxt = cell_val[i];
    end
    rms_map_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .index     (MAP_W'(i)),
      .from_next (nxt),
      .value     (cell_val[i])
    );
  end

  // Lookup: each cell drives the bus when its position matches
  always_comb begin
    value = '0;
    for (int i = 0; i < MAP_DEPTH; i++) begin
      value = value | ((index == MAP_W'(i)) ? cell_val[i] : '0);
    end
  end

endmodule

### rtl/remapped_matrix_store.sv
`timescale 1ns / 1ps

// Matrix store with row/column remap. One item is in work at a time: read,
// write, remove row, remove column and restart without clear each pass
// through capture, remap-chain lookup, grid RAM or chain update and result
// register before the next acceptance. The last of those steps also waits
// for as long as out_stall holds the previous item's result in the output
// register. Restart with clear_grid set walks the single-port grid RAM one
// element per cycle through GRID_DEPTH cells (4096 at the default size).
// Remaps live in two chains of cells, shifted in place on a remove. A
// result waits in the output register while the next item is accepted. Grid
// contents are undefined after reset until written or cleared by a restart.
module remapped_matrix_store (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rms_pkg::OP_W-1:0]       op,
  input  logic [rms_pkg::COL_FW-1:0]     col,
  input  logic [rms_pkg::ROW_FW-1:0]     row,
  input  logic signed [rms_pkg::VAL_W-1:0] value,
  input  logic                           clear_grid,
  input  logic                           cfg_write,
  input  logic [rms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rms_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [rms_pkg::VAL_W-1:0] read_value,
  output logic                           status,
  output logic [rms_pkg::CNT_FW-1:0]     columns_now,
  output logic [rms_pkg::CNT_FW-1:0]     rows_now
);

  import rms_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAP   = 3'd1;
  localparam logic [2:0] S_MEM   = 3'd2;
  localparam logic [2:0] S_CLEAR = 3'd3;
  localparam logic [2:0] S_DATA  = 3'd4;

  logic [2:0]               state;
  logic [CNT_FW-1:0]        start_columns;
  logic [CNT_FW-1:0]        start_rows;
  logic [CCNT_W-1:0]        col_count;
  logic [RCNT_W-1:0]        row_count;

  logic [OP_W-1:0]          op_q;
  logic [COL_FW-1:0]        col_q;
  logic [ROW_FW-1:0]        row_q;
  logic signed [VAL_W-1:0]  value_q;
  logic                     clear_q;
  logic                     col_ok_q;
  logic                     row_ok_q;
  logic [ADDR_W-1:0]        addr_q;
  logic [ADDR_W-1:0]        clr_addr;
  logic                     status_q;

  map_ctrl_t                col_ctrl;
  map_ctrl_t                row_ctrl;
  logic [MAP_W-1:0]         col_phys;
  logic [MAP_W-1:0]         row_phys;

  logic                     ram_en;
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_addr;
  logic [ELEMENT_WIDTH-1:0] ram_wdata;
  logic [ELEMENT_WIDTH-1:0] ram_rdata;

  assign in_stall = (state != S_IDLE);

  rms_map_chain u_col_chain (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (col_ctrl),
    .index (MAP_W'(col_q)),
    .value (col_phys)
  );

  rms_map_chain u_row_chain (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (row_ctrl),
    .index (MAP_W'(row_q)),
    .value (row_phys)
  );

  rms_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (GRID_DEPTH)
  ) u_grid (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Chain and grid control for the current step
  always_comb begin
    col_ctrl  = '0;
    row_ctrl  = '0;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = addr_q;
    ram_wdata = to_elem(value_q);
    case (state)
      S_MEM: begin
        case (op_q)
          OP_READ: begin
            ram_en = col_ok_q && row_ok_q;
          end
          OP_WRITE: begin
            ram_en = col_ok_q && row_ok_q;
            ram_we = col_ok_q && row_ok_q;
          end
          OP_REMOVE_ROW: begin
            row_ctrl.shift = row_ok_q;
            row_ctrl.pos   = MAP_W'(row_q);
          end
          OP_REMOVE_COL: begin
            col_ctrl.shift = col_ok_q;
            col_ctrl.pos   = MAP_W'(col_q);
          end
          OP_RESTART: begin
            col_ctrl.restart = 1'b1;
            row_ctrl.restart = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = '0;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, counts, config and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      start_columns <= START_RESET;
      start_rows    <= START_RESET;
      col_count     <= CCNT_W'(clamp_size(START_RESET, MAX_COLUMNS));
      row_count     <= RCNT_W'(clamp_size(START_RESET, MAX_ROWS));
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_START_COLUMNS) start_columns <= cfg_data;
        else if (cfg_index == CFG_START_ROWS) start_rows <= cfg_data;
      end

      // result taken; in S_DATA the result register is handled below
      if (out_valid && !out_stall && (state != S_DATA)) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q    <= op;
            col_q   <= col;
            row_q   <= row;
            value_q <= value;
            clear_q <= clear_grid;
            state   <= S_MAP;
          end
        end
        S_MAP: begin
          col_ok_q <= (32'(col_q) < 32'(col_count));
          row_ok_q <= (32'(row_q) < 32'(row_count));
          addr_q   <= ADDR_W'(32'(row_phys) * MAX_COLUMNS + 32'(col_phys));
          state    <= S_MEM;
        end
        S_MEM: begin
          state <= S_DATA;
          case (op_q)
            OP_READ, OP_WRITE: begin
              status_q <= !(col_ok_q && row_ok_q);
            end
            OP_REMOVE_ROW: begin
              status_q <= !row_ok_q;
              if (row_ok_q) row_count <= row_count - 1'b1;
            end
            OP_REMOVE_COL: begin
              status_q <= !col_ok_q;
              if (col_ok_q) col_count <= col_count - 1'b1;
            end
            OP_RESTART: begin
              status_q  <= 1'b0;
              col_count <= CCNT_W'(clamp_size(start_columns, MAX_COLUMNS));
              row_count <= RCNT_W'(clamp_size(start_rows, MAX_ROWS));
              if (clear_q) begin
                clr_addr <= '0;
                state    <= S_CLEAR;
              end
            end
            default: begin
              status_q <= 1'b1;
            end
          endcase
        end
        S_CLEAR: begin
          if (clr_addr == ADDR_W'(GRID_DEPTH - 1)) state <= S_DATA;
          else clr_addr <= clr_addr + 1'b1;
        end
        S_DATA: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            read_value  <= (op_q == OP_READ && col_ok_q && row_ok_q) ?
                           from_elem(ram_rdata) : '0;
            status      <= status_q;
            columns_now <= CNT_FW'(col_count);
            rows_now    <= CNT_FW'(row_count);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/rms_checker.sv
`timescale 1ns / 1ps

module rms_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic signed [rms_pkg::VAL_W-1:0] read_value,
  input logic                           status,
  input logic [rms_pkg::CNT_FW-1:0]     columns_now,
  input logic [rms_pkg::CNT_FW-1:0]     rows_now
);

  import rms_pkg::*;

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // One item at a time: the block stalls the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  // A failed item never returns data
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (read_value == '0))
    else $error("nonzero read value with error status");

  // Logical sizes never exceed the grid
  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(columns_now) <= MAX_COLUMNS && 32'(rows_now) <= MAX_ROWS))
    else $error("logical size beyond grid");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(read_value) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind remapped_matrix_store rms_checker u_rms_checker (.*);

### bench/remapped_matrix_store_test.sv
`timescale 1ns / 1ps

module remapped_matrix_store_test;
  import rms_pkg::*;

  // Status codes and op codes the block leaves undefined
  localparam logic ST_DONE  = 1'b0;
  localparam logic ST_RANGE = 1'b1;
  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [OP_W-1:0] OP_LAST_CODE    = 3'd7;
  // Register indexes past the two real ones, which the block ignores
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 150;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_REPORTS = 10;

  // One input item, plus an optional register update before it and an
  // optional hand-typed expectation
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COL_FW-1:0] col;
    logic [ROW_FW-1:0] row;
    logic [VAL_W-1:0]  value;
    logic              clear;
    logic              cfg;
    logic [CNT_FW-1:0] cfg_cols;
    logic [CNT_FW-1:0] cfg_rows;
    logic              fixed;
    logic [VAL_W-1:0]  want_rd;
    logic              want_st;
    logic [CNT_FW-1:0] want_cols;
    logic [CNT_FW-1:0] want_rows;
  } stim_t;

  typedef struct packed {
    logic [VAL_W-1:0]  rd;
    logic              st;
    logic [CNT_FW-1:0] cols;
    logic [CNT_FW-1:0] rows;
  } result_t;

  localparam int DIR_ROWS = 27;

  // op, col, row, value, clear, cfg, cfg_cols, cfg_rows,
  // fixed, want_rd, want_st, want_cols, want_rows
  stim_t dir_table [DIR_ROWS] = '{
    '{OP_LAST_CODE, 0, 0, 0, 0, 0, 0, 0, 1, 0, ST_RANGE, 64, 64},
    '{OP_RESTART, 0, 0, 0, 1, 0, 0, 0, 1, 0, ST_DONE, 64, 64},
    '{OP_READ, 63, 63, 0, 0, 0, 0, 0, 1, 0, ST_DONE, 64, 64},
    '{OP_WRITE, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 1, 0, ST_DONE, 64, 64},
    '{OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, 32'h7FFF_FFFF, ST_DONE, 64, 64},
    '{OP_WRITE, 63, 63, 32'h8000_0000, 1, 0, 0, 0, 1, 0, ST_DONE, 64, 64},
    '{OP_READ, 63, 63, 0, 0, 0, 0, 0, 1, 32'h8000_0000, ST_DONE, 64, 64},
    '{OP_WRITE, 5, 7, 32'hFFFF_FFFF, 0, 0, 0, 0, 1, 0, ST_DONE, 64, 64},
    '{OP_READ, 5, 7, 0, 0, 0, 0, 0, 1, 32'hFFFF_FFFF, ST_DONE, 64, 64},
    '{OP_FIRST_UNUSED, 0, 0, 0, 1, 0, 0, 0, 1, 0, ST_RANGE, 64, 64},
    '{OP_REMOVE_ROW, 63, 0, 0, 0, 0, 0, 0, 1, 0, ST_DONE, 64, 63},
    '{OP_REMOVE_ROW, 0, 63, 0, 0, 0, 0, 0, 1, 0, ST_RANGE, 64, 63},
    '{OP_READ, 5, 6, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{OP_REMOVE_COL, 63, 0, 0, 0, 0, 0, 0, 1, 0, ST_DONE, 63, 63},
    '{OP_REMOVE_COL, 63, 0, 0, 0, 0, 0, 0, 1, 0, ST_RANGE, 63, 63},
    '{OP_READ, 62, 62, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{OP_WRITE, 63, 0, 1, 0, 0, 0, 0, 1, 0, ST_RANGE, 63, 63},
    '{OP_WRITE, 0, 63, 1, 0, 0, 0, 0, 1, 0, ST_RANGE, 63, 63},
    '{OP_REMOVE_COL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{OP_READ, 4, 6, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{OP_RESTART, 0, 0, 0, 0, 0, 0, 0, 1, 0, ST_DONE, 64, 64},
    '{OP_READ, 63, 63, 0, 0, 0, 0, 0, 1, 32'h8000_0000, ST_DONE, 64, 64},
    '{OP_RESTART, 0, 0, 0, 0, 1, 0, 127, 1, 0, ST_DONE, 1, 64},
    '{OP_REMOVE_COL, 0, 0, 0, 0, 0, 0, 0, 1, 0, ST_DONE, 0, 64},
    '{OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, 0, ST_RANGE, 0, 64},
    '{OP_REMOVE_ROW, 0, 0, 0, 0, 0, 0, 0, 1, 0, ST_DONE, 0, 63},
    '{OP_RESTART, 0, 0, 0, 1, 1, 64, 64, 1, 0, ST_DONE, 64, 64}
  };

  // Register settings per random phase; -1 picks a random value
  int phase_cols [PHASES] = '{64, 1, 0, 127, -1, 64, -1};
  int phase_rows [PHASES] = '{64, 1, 127, 0, -1, 64, -1};

  logic clk;
  logic rst        = 1'b1;
  logic in_valid   = 1'b0;
  logic out_stall  = 1'b0;
  logic cfg_write  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  stim_t cur_item = '0;

  logic                    in_stall;
  logic                    out_valid;
  logic signed [VAL_W-1:0] read_value;
  logic                    status;
  logic [CNT_FW-1:0]       columns_now;
  logic [CNT_FW-1:0]       rows_now;

  // Shadow of the store
  logic [VAL_W-1:0]  grid_cells [GRID_DEPTH];
  logic [MAP_W-1:0]  col_map [MAP_DEPTH];
  logic [MAP_W-1:0]  row_map [MAP_DEPTH];
  logic [CNT_FW-1:0] col_count;
  logic [CNT_FW-1:0] row_count;
  logic [CNT_FW-1:0] start_cols;
  logic [CNT_FW-1:0] start_rows;

  result_t pending_results [$];
  int      bad_results = 0;
  int      cycle_count = 0;
  bit      no_idle     = 1'b0;
  int      stall_left  = 0;

  remapped_matrix_store u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (cur_item.op),
    .col         (cur_item.col),
    .row         (cur_item.row),
    .value       (cur_item.value),
    .clear_grid  (cur_item.clear),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_value  (read_value),
    .status      (status),
    .columns_now (columns_now),
    .rows_now    (rows_now)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Restart size: zero means one, oversize means the grid size
  function automatic logic [CNT_FW-1:0] fit_size(logic [CNT_FW-1:0] v, int top);
    if (v == 0) return CNT_FW'(1);
    if (int'(v) > top) return CNT_FW'(top);
    return v;
  endfunction

  // Apply one item to the shadow store and return the result it gives
  function automatic result_t apply_matrix_op(stim_t it);
    result_t res;
    int      grid_idx;
    res = '0;
    res.st = ST_DONE;
    grid_idx = int'(row_map[it.row]) * MAX_COLUMNS + int'(col_map[it.col]);
    case (it.op)
      OP_READ: begin
        if (it.col < col_count && it.row < row_count) res.rd = grid_cells[grid_idx];
        else res.st = ST_RANGE;
      end
      OP_WRITE: begin
        if (it.col < col_count && it.row < row_count) grid_cells[grid_idx] = it.value;
        else res.st = ST_RANGE;
      end
      OP_REMOVE_ROW: begin
        if (it.row < row_count) begin
          for (int i = it.row; i + 1 < row_count; i++) row_map[i] = row_map[i + 1];
          row_count--;
        end else begin
          res.st = ST_RANGE;
        end
      end
      OP_REMOVE_COL: begin
        if (it.col < col_count) begin
          for (int i = it.col; i + 1 < col_count; i++) col_map[i] = col_map[i + 1];
          col_count--;
        end else begin
          res.st = ST_RANGE;
        end
      end
      OP_RESTART: begin
        for (int i = 0; i < MAP_DEPTH; i++) begin
          col_map[i] = MAP_W'(i);
          row_map[i] = MAP_W'(i);
        end
        col_count = fit_size(start_cols, MAX_COLUMNS);
        row_count = fit_size(start_rows, MAX_ROWS);
        if (it.clear) begin
          for (int i = 0; i < GRID_DEPTH; i++) grid_cells[i] = '0;
        end
      end
      default: res.st = ST_RANGE;
    endcase
    res.cols = col_count;
    res.rows = row_count;
    return res;
  endfunction

  // Gap or stall length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Index biased to the live range, its low corner and its edges
  function automatic logic [5:0] pick_index(logic [CNT_FW-1:0] cnt);
    int r;
    r = $urandom_range(0, 9);
    if (cnt == 0 || r == 0) return 6'($urandom_range(0, 63));
    if (r < 5) return 6'($urandom_range(0, (cnt > 4) ? 3 : cnt - 1));
    if (r == 5) return 6'(cnt - 1);
    if (r == 6 && cnt < 64) return 6'(cnt);
    return 6'($urandom_range(0, cnt - 1));
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic stim_t random_item();
    stim_t it;
    int    r;
    it = '0;
    r = $urandom_range(0, 99);
    it.col   = pick_index(col_count);
    it.row   = pick_index(row_count);
    it.value = pick_value();
    it.clear = 1'($urandom_range(0, 1));
    if (r < 38) it.op = OP_READ;
    else if (r < 72) it.op = OP_WRITE;
    else if (r < 80) it.op = OP_REMOVE_ROW;
    else if (r < 88) it.op = OP_REMOVE_COL;
    else if (r < 93) begin
      it.op = OP_RESTART;
      it.clear = ($urandom_range(0, 4) == 0);
    end else if (r < 96) begin
      it.op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
    end else begin
      // noise: any op, any index; clearing restarts stay rare
      it.op  = OP_W'($urandom_range(0, OP_LAST_CODE));
      it.col = 6'($urandom);
      it.row = 6'($urandom);
      if (it.op == OP_RESTART) it.clear = ($urandom_range(0, 7) == 0);
    end
    return it;
  endfunction

  function automatic logic [CNT_FW-1:0] pick_cfg(int v);
    return (v < 0) ? CNT_FW'($urandom_range(0, 127)) : CNT_FW'(v);
  endfunction

  // Present one item after a random gap and hold it until taken
  task automatic send_item(stim_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cur_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // Stop sending and wait until every expected result is back
  task automatic settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == CFG_START_COLUMNS) start_cols = data;
    else if (idx == CFG_START_ROWS) start_rows = data;
  endtask

  // Both sizes, plus one write to an index the block ignores
  task automatic configure(logic [CNT_FW-1:0] cols, logic [CNT_FW-1:0] rows);
    write_reg(CFG_START_COLUMNS, cols);
    write_reg(CFG_START_ROWS, rows);
    write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 7'($urandom));
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Receiver side: random stall bursts, off in the quiet phase
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (!no_idle && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left = pick_gap();
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check results first, then log the item taken at the same edge
  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          bad_results++;
          if (bad_results <= MAX_REPORTS)
            $display("cycle %0d: result with no item pending", cycle_count);
        end else begin
          want = pending_results.pop_front();
          if (read_value !== want.rd || status !== want.st ||
              columns_now !== want.cols || rows_now !== want.rows) begin
            bad_results++;
            if (bad_results <= MAX_REPORTS)
              $display({"cycle %0d: expected rd %h st %0d cols %0d rows %0d, ",
                        "got rd %h st %0d cols %0d rows %0d"},
                       cycle_count, want.rd, want.st, want.cols, want.rows,
                       read_value, status, columns_now, rows_now);
          end
        end
      end
      if (in_valid && !in_stall) begin
        got = apply_matrix_op(cur_item);
        if (cur_item.fixed)
          got = '{cur_item.want_rd, cur_item.want_st, cur_item.want_cols, cur_item.want_rows};
        pending_results.push_back(got);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : main
    stim_t it;
    // shadow state after reset; the grid is filled by the first clearing restart
    for (int i = 0; i < MAP_DEPTH; i++) begin
      col_map[i] = MAP_W'(i);
      row_map[i] = MAP_W'(i);
    end
    start_cols = START_RESET;
    start_rows = START_RESET;
    col_count  = START_RESET;
    row_count  = START_RESET;
    for (int i = 0; i < GRID_DEPTH; i++) grid_cells[i] = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    for (int k = 0; k < DIR_ROWS; k++) begin
      if (dir_table[k].cfg) begin
        settle_idle();
        configure(dir_table[k].cfg_cols, dir_table[k].cfg_rows);
      end
      send_item(dir_table[k]);
    end

    // Random phases, each opened by a restart under fresh sizes
    for (int p = 0; p < PHASES; p++) begin
      settle_idle();
      configure(pick_cfg(phase_cols[p]), pick_cfg(phase_rows[p]));
      no_idle = (p == 5);
      it = '0;
      it.op = OP_RESTART;
      it.clear = ($urandom_range(0, 2) == 0);
      send_item(it);
      repeat (PHASE_ITEMS) send_item(random_item());
    end

    no_idle = 1'b0;
    settle_idle();
    repeat (20) @(posedge clk);
    if (bad_results == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
